// ===== rtl/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mfb_pkg
// shared types and constants of the mel filterbank accumulate unit
// ----------------------------------------------------------------------------
package mfb_pkg;

	localparam int MAX_BINS_DEF     = 256;
	localparam int MAX_FILTERS_DEF  = 32;

	localparam int FC_W             = 6;
	localparam logic [FC_W-1:0] FILTER_COUNT_RST = 6'd23;
	localparam int CNT_W            = 7;

	localparam int ADDR_W           = 8;
	localparam int POWER_W          = 32;
	localparam int WEIGHT_W         = 16;
	localparam int FILT_W           = 5;
	localparam int PROD_W           = 48;
	localparam int ACC_W            = 58;
	localparam int ACC_SHIFT        = 15;
	localparam int ENERGY_W         = 48;

	localparam int S_DATA_W         = 80;
	localparam int M_DATA_W         = 56;

	// operation carried on the input tuser
	typedef enum logic {
		OP_TABLE_WRITE = 1'b0,
		OP_SAMPLE      = 1'b1
	} mel_op_t;

	// weight table entry, first filter in the lowest bits
	typedef struct packed {
		logic                use_next;
		logic                use_first;
		logic [WEIGHT_W-1:0] weight_next;
		logic [WEIGHT_W-1:0] weight_first;
		logic [FILT_W-1:0]   first_filter;
	} wt_entry_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} acc_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENTRY,
		ST_ADD1,
		ST_ADD2,
		ST_FRD,
		ST_FLD
	} state_t;

endpackage

// ===== rtl/mfb_weight_mem.sv =====
// ----------------------------------------------------------------------------
// mfb_weight_mem
// per-bin weight table, one write and one registered read port
// ----------------------------------------------------------------------------
module mfb_weight_mem #(
	parameter int MAX_BINS = mfb_pkg::MAX_BINS_DEF,
	localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [BW-1:0]       wr_addr,
	input  mfb_pkg::wt_entry_t  wr_data,
	input  logic                rd_en,
	input  logic [BW-1:0]       rd_addr,
	output mfb_pkg::wt_entry_t  rd_data
);

	mfb_pkg::wt_entry_t mem [MAX_BINS];
	mfb_pkg::wt_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_data = rdata_q;

endmodule

// ===== rtl/mfb_acc_unit.sv =====
// ----------------------------------------------------------------------------
// mfb_acc_unit
// accumulator memory with per-entry valid bits and saturating add on write
// ----------------------------------------------------------------------------
module mfb_acc_unit #(
	parameter int MAX_FILTERS = mfb_pkg::MAX_FILTERS_DEF,
	localparam int AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mfb_pkg::acc_ctl_t           ctl,
	input  logic [AW-1:0]               rd_addr,
	input  logic [AW-1:0]               wr_addr,
	input  logic [mfb_pkg::PROD_W-1:0]  addend,
	output logic [mfb_pkg::ACC_W-1:0]   rd_data
);

	localparam int ACC_W = mfb_pkg::ACC_W;

	logic [ACC_W-1:0]       mem [MAX_FILTERS];
	logic [ACC_W-1:0]       rdata_q;
	logic                   rvalid_q;
	logic [MAX_FILTERS-1:0] valid_q;
	logic [ACC_W:0]         sum;
	logic [ACC_W-1:0]       sum_sat;

	// an entry not written since reset or flush reads as zero
	assign rd_data = rvalid_q ? rdata_q : '0;
	assign sum     = {1'b0, rd_data} + (ACC_W+1)'(addend);
	assign sum_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata_q <= mem[rd_addr];
		end
		if (ctl.wr) begin
			mem[wr_addr] <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			valid_q  <= '0;
		end else begin
			if (ctl.rd) begin
				rvalid_q <= valid_q[rd_addr];
			end
			if (ctl.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (ctl.clr) begin
				valid_q[wr_addr] <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/mel_filterbank_accumulate_unit.sv =====
// ----------------------------------------------------------------------------
// mel_filterbank_accumulate_unit
// triangular mel filterbank: per-bin weighted power into two accumulators
// table write: taken in idle; sample: weight read, then two accumulator
// read-modify-writes through the accumulator memory, one read and one write port
// frame end adds a flush, a read state and a load state per filter (load stalls on output)
// reset: accumulators read zero at once (valid bits), filter_count = 23,
// weight table undefined until written
// ----------------------------------------------------------------------------
module mel_filterbank_accumulate_unit #(
	parameter int MAX_BINS    = mfb_pkg::MAX_BINS_DEF,
	parameter int MAX_FILTERS = mfb_pkg::MAX_FILTERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [mfb_pkg::FC_W-1:0]      cfg_wdata,     // filter_count
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// table_address, power, first_filter, weight_first, weight_next,
	// use_first, use_next, zero pad
	input  logic [mfb_pkg::S_DATA_W-1:0]  s_axis_tdata,
	input  logic                          s_axis_tlast,  // frame_end
	input  logic                          s_axis_tuser,  // operation
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [mfb_pkg::M_DATA_W-1:0]  m_axis_tdata,  // channel, energy, zero pad
	output logic                          m_axis_tlast   // last_channel
);

	localparam int BW       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int AW       = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
	localparam int CW       = mfb_pkg::CNT_W;
	localparam int FW       = mfb_pkg::FILT_W;
	localparam int PW       = mfb_pkg::PROD_W;
	localparam int EW       = mfb_pkg::ENERGY_W;
	localparam int AccW     = mfb_pkg::ACC_W;
	localparam int PAD_W    = mfb_pkg::M_DATA_W - FW - EW;

	mfb_pkg::state_t     state_q, state_d;
	mfb_pkg::wt_entry_t  in_entry, entry;
	mfb_pkg::acc_ctl_t   acc_ctl;

	logic [mfb_pkg::ADDR_W-1:0]   in_addr;
	logic [mfb_pkg::POWER_W-1:0]  in_power;
	logic                         wt_we, wt_re;
	logic [AW-1:0]                acc_rd_addr, acc_wr_addr;
	logic [AccW-1:0]              acc_rd_data;

	logic [mfb_pkg::FC_W-1:0]     fc_q;
	logic [CW-1:0]                n_eff;
	logic [CW-1:0]                f_idx, f_nxt, k_q;
	logic                         first_ok, next_ok, last_k, out_load;
	logic [mfb_pkg::POWER_W-1:0]  power_q;
	logic                         fend_q;
	logic [BW-1:0]                bin_q;
	logic [PW-1:0]                prod_q;

	logic                         out_valid_q;
	logic [FW-1:0]                out_channel_q;
	logic [EW-1:0]                out_energy_q;
	logic                         out_last_q;

	assign in_addr  = s_axis_tdata[7:0];
	assign in_power = s_axis_tdata[39:8];
	assign in_entry = mfb_pkg::wt_entry_t'(s_axis_tdata[78:40]);

	always_comb begin
		if (fc_q == '0) begin
			n_eff = CW'(1);
		end else if (CW'(fc_q) > CW'(MAX_FILTERS)) begin
			n_eff = CW'(MAX_FILTERS);
		end else begin
			n_eff = CW'(fc_q);
		end
	end

	assign f_idx    = CW'(entry.first_filter);
	assign f_nxt    = f_idx + CW'(1);
	assign first_ok = f_idx < n_eff;
	assign next_ok  = f_nxt < n_eff;
	assign last_k   = k_q == (n_eff - CW'(1));

	mfb_weight_mem #(
		.MAX_BINS (MAX_BINS)
	) u_weight_mem (
		.clk     (clk),
		.wr_en   (wt_we),
		.wr_addr (BW'(in_addr)),
		.wr_data (in_entry),
		.rd_en   (wt_re),
		.rd_addr (bin_q),
		.rd_data (entry)
	);

	mfb_acc_unit #(
		.MAX_FILTERS (MAX_FILTERS)
	) u_acc_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.rd_addr (acc_rd_addr),
		.wr_addr (acc_wr_addr),
		.addend  (prod_q),
		.rd_data (acc_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		wt_we         = 1'b0;
		wt_re         = 1'b0;
		acc_ctl       = '0;
		acc_rd_addr   = '0;
		acc_wr_addr   = '0;
		out_load      = 1'b0;
		case (state_q)
			mfb_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser == mfb_pkg::OP_TABLE_WRITE) begin
						wt_we = int'(in_addr) < MAX_BINS;
					end else begin
						wt_re   = 1'b1;
						state_d = mfb_pkg::ST_ENTRY;
					end
				end
			end
			mfb_pkg::ST_ENTRY: begin
				acc_ctl.rd  = first_ok;
				acc_rd_addr = AW'(f_idx);
				state_d     = mfb_pkg::ST_ADD1;
			end
			mfb_pkg::ST_ADD1: begin
				acc_ctl.wr  = entry.use_first && first_ok;
				acc_wr_addr = AW'(f_idx);
				acc_ctl.rd  = next_ok;
				acc_rd_addr = AW'(f_nxt);
				state_d     = mfb_pkg::ST_ADD2;
			end
			mfb_pkg::ST_ADD2: begin
				acc_ctl.wr  = entry.use_next && next_ok;
				acc_wr_addr = AW'(f_nxt);
				state_d     = fend_q ? mfb_pkg::ST_FRD : mfb_pkg::ST_IDLE;
			end
			mfb_pkg::ST_FRD: begin
				acc_ctl.rd  = 1'b1;
				acc_rd_addr = AW'(k_q);
				state_d     = mfb_pkg::ST_FLD;
			end
			mfb_pkg::ST_FLD: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load    = 1'b1;
					acc_ctl.clr = 1'b1;
					acc_wr_addr = AW'(k_q);
					state_d     = last_k ? mfb_pkg::ST_IDLE : mfb_pkg::ST_FRD;
				end
			end
			default: begin
				state_d = mfb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= mfb_pkg::FILTER_COUNT_RST;
			bin_q <= '0;
			k_q   <= '0;
		end else begin
			if (cfg_wen) begin
				fc_q <= cfg_wdata;
			end
			if (state_q == mfb_pkg::ST_ADD2) begin
				k_q <= '0;
				if (fend_q || bin_q == BW'(MAX_BINS - 1)) begin
					bin_q <= '0;
				end else begin
					bin_q <= bin_q + BW'(1);
				end
			end
			if (out_load) begin
				k_q <= k_q + CW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready && s_axis_tuser == mfb_pkg::OP_SAMPLE) begin
			power_q <= in_power;
			fend_q  <= s_axis_tlast;
		end
		if (state_q == mfb_pkg::ST_ENTRY) begin
			prod_q <= PW'(power_q) * PW'(entry.weight_first);
		end else if (state_q == mfb_pkg::ST_ADD1) begin
			prod_q <= PW'(power_q) * PW'(entry.weight_next);
		end
		if (out_load) begin
			out_channel_q <= k_q[FW-1:0];
			out_energy_q  <= EW'(acc_rd_data >> mfb_pkg::ACC_SHIFT);
			out_last_q    <= last_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_energy_q, out_channel_q};
	assign m_axis_tlast  = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mfb_pkg::ST_FLD))
		else $error("energy word loaded outside flush");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfb_pkg::ST_FLD || state_q == mfb_pkg::ST_FRD) |-> k_q < n_eff)
		else $error("flush channel beyond filter count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> out_channel_q == FW'(n_eff - CW'(1)))
		else $error("last channel flag on wrong channel");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the mel filterbank accumulate unit: loads weight
// entries and spectrum frames, predicts every mel energy word in order and
// compares it field by field, across several filter counts
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_W          = mfb_pkg::ADDR_W;
	localparam int POWER_W         = mfb_pkg::POWER_W;
	localparam int WEIGHT_W        = mfb_pkg::WEIGHT_W;
	localparam int FILT_W          = mfb_pkg::FILT_W;
	localparam int PROD_W          = mfb_pkg::PROD_W;
	localparam int ACC_W           = mfb_pkg::ACC_W;
	localparam int ACC_SHIFT       = mfb_pkg::ACC_SHIFT;
	localparam int ENERGY_W        = mfb_pkg::ENERGY_W;
	localparam int FC_W            = mfb_pkg::FC_W;
	localparam int S_DATA_W        = mfb_pkg::S_DATA_W;
	localparam int M_DATA_W        = mfb_pkg::M_DATA_W;
	localparam int MAX_BINS_DEF    = mfb_pkg::MAX_BINS_DEF;
	localparam int MAX_FILTERS_DEF = mfb_pkg::MAX_FILTERS_DEF;

	typedef struct {
		mfb_pkg::mel_op_t     op;
		logic [ADDR_W-1:0]    addr;
		logic [POWER_W-1:0]   power;
		logic                 fend;
		mfb_pkg::wt_entry_t   ent;
	} bin_word_t;

	typedef struct {
		logic [FILT_W-1:0]    channel;
		logic [ENERGY_W-1:0]  energy;
		logic                 last;
	} mel_energy_t;

	localparam int STALL_LIMIT = 1000;
	localparam logic [ACC_W-1:0] ACC_TOP = '1;
	localparam logic [ACC_W-1:0] ENERGY_TOP = {{(ACC_W-ENERGY_W){1'b0}}, {ENERGY_W{1'b1}}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [FC_W-1:0]      cfg_wdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_axis_tdata;
	logic                 m_axis_tlast;

	// predictor state
	mfb_pkg::wt_entry_t   wt_store [MAX_BINS_DEF];
	logic [ACC_W-1:0]     acc_sum [MAX_FILTERS_DEF];
	logic [ADDR_W-1:0]    bin_pos = '0;
	logic [FC_W-1:0]      fc_reg = mfb_pkg::FILTER_COUNT_RST;

	// stimulus state
	bin_word_t            bin_words [$];
	mel_energy_t          energy_due [$];
	bit                   gen_written [MAX_BINS_DEF];
	logic [ADDR_W-1:0]    gen_bin = '0;
	bin_word_t            cur_word;
	bit                   gaps_on = 1'b1;
	int                   gap_left;
	int                   stall_left;
	int                   quiet_cycles = 0;
	int                   queued = 0;
	int                   mismatches = 0;
	int                   writes_seen = 0;
	int                   samples_seen = 0;
	int                   frames_seen = 0;
	int                   energies_checked = 0;

	always #6 clk = ~clk;

	mel_filterbank_accumulate_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	function automatic int hold_off();
		return gaps_on ? $urandom_range(0, 15) : 0;
	endfunction

	function automatic void add_product(int unsigned filt, logic [POWER_W-1:0] pwr,
			logic [WEIGHT_W-1:0] wgt, int unsigned n);
		logic [PROD_W-1:0] prod;
		logic [ACC_W:0]    sum;
		if (filt >= n)
			return;
		prod = pwr * wgt;
		sum = acc_sum[filt] + prod;
		if (sum > {1'b0, ACC_TOP})
			sum = {1'b0, ACC_TOP};
		acc_sum[filt] = sum[ACC_W-1:0];
	endfunction

	function automatic void mel_accumulate(bin_word_t w);
		mfb_pkg::wt_entry_t e;
		int unsigned        n;
		mel_energy_t        r;
		logic [ACC_W-1:0]   shifted;
		if (w.op == mfb_pkg::OP_TABLE_WRITE) begin
			wt_store[w.addr] = w.ent;
			writes_seen++;
			return;
		end
		samples_seen++;
		n = (fc_reg == 0) ? 1 : (fc_reg > MAX_FILTERS_DEF) ? MAX_FILTERS_DEF : fc_reg;
		e = wt_store[bin_pos];
		if (e.use_first)
			add_product(e.first_filter, w.power, e.weight_first, n);
		if (e.use_next)
			add_product(int'(e.first_filter) + 1, w.power, e.weight_next, n);
		if (!w.fend) begin
			bin_pos = bin_pos + 1'b1;
			return;
		end
		for (int k = 0; k < n; k++) begin
			shifted = acc_sum[k] >> ACC_SHIFT;
			r.channel = FILT_W'(k);
			r.energy = (shifted > ENERGY_TOP) ? ENERGY_TOP[ENERGY_W-1:0] : shifted[ENERGY_W-1:0];
			r.last = (k == n - 1);
			energy_due.insert(energy_due.size(), r);
		end
		foreach (acc_sum[k])
			acc_sum[k] = '0;
		bin_pos = '0;
		frames_seen++;
	endfunction

	task automatic log_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got 0x%0h, expected 0x%0h (word %0d)",
			field, got, want, energies_checked);
		mismatches++;
	endtask

	function automatic mfb_pkg::wt_entry_t mk_entry(logic [FILT_W-1:0] ff,
			logic [WEIGHT_W-1:0] wf, logic [WEIGHT_W-1:0] wn, logic uf, logic un);
		return {un, uf, wn, wf, ff};
	endfunction

	function automatic logic [WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'd32768;
			2: return '1;
			3: return WEIGHT_W'($urandom);
			default: return WEIGHT_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [POWER_W-1:0] rand_power();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return POWER_W'($urandom_range(0, 255));
			default: return POWER_W'($urandom);
		endcase
	endfunction

	function automatic mfb_pkg::wt_entry_t rand_entry();
		return mk_entry(FILT_W'($urandom_range(0, 31)), rand_weight(), rand_weight(),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	function automatic void queue_write(logic [ADDR_W-1:0] addr, mfb_pkg::wt_entry_t ent);
		bin_word_t w;
		w.op = mfb_pkg::OP_TABLE_WRITE;
		w.addr = addr;
		w.power = POWER_W'($urandom);
		w.fend = 1'($urandom_range(0, 1));
		w.ent = ent;
		bin_words.insert(bin_words.size(), w);
		gen_written[addr] = 1'b1;
		queued++;
	endfunction

	// a sample never reads an entry that was not loaded
	function automatic void queue_sample(logic [POWER_W-1:0] pwr, logic fend);
		bin_word_t w;
		if (!gen_written[gen_bin])
			queue_write(gen_bin, rand_entry());
		w.op = mfb_pkg::OP_SAMPLE;
		w.addr = ADDR_W'($urandom);
		w.power = pwr;
		w.fend = fend;
		w.ent = rand_entry();
		bin_words.insert(bin_words.size(), w);
		gen_bin = fend ? '0 : gen_bin + 1'b1;
		queued++;
	endfunction

	function automatic void queue_frame();
		int len;
		len = $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 4) == 0)
				queue_write(ADDR_W'($urandom), rand_entry());
			queue_sample(rand_power(), i == len - 1);
		end
	endfunction

	task automatic drain();
		do
			@(negedge clk);
		while (bin_words.size() != 0 || s_axis_tvalid || energy_due.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_filter_count(logic [FC_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		fc_reg = value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				mel_accumulate(cur_word);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					s_axis_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (bin_words.size() > 0) begin
					cur_word = bin_words.pop_front();
					s_axis_tdata <= {1'b0, cur_word.ent, cur_word.power, cur_word.addr};
					s_axis_tlast <= cur_word.fend;
					s_axis_tuser <= cur_word.op;
					s_axis_tvalid <= 1'b1;
					gap_left <= hold_off();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		int          nstall;
		mel_energy_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			nstall = stall_left;
			if (m_axis_tvalid && m_axis_tready) begin
				if (energy_due.size() == 0) begin
					log_mismatch("unexpected word, channel", m_axis_tdata[FILT_W-1:0], '0);
				end else begin
					want = energy_due.pop_front();
					if (m_axis_tdata[FILT_W-1:0] !== want.channel)
						log_mismatch("channel", m_axis_tdata[FILT_W-1:0], want.channel);
					if (m_axis_tdata[FILT_W+ENERGY_W-1:FILT_W] !== want.energy)
						log_mismatch("energy", m_axis_tdata[FILT_W+ENERGY_W-1:FILT_W],
							want.energy);
					if (m_axis_tlast !== want.last)
						log_mismatch("last_channel", m_axis_tlast, want.last);
				end
				energies_checked++;
				nstall = hold_off();
			end
			if (nstall > 0) begin
				m_axis_tready <= 1'b0;
				stall_left <= nstall - 1;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [FC_W-1:0] fc_plan [6];
		int              target;
		fc_plan = '{6'd1, 6'd0, 6'd32, 6'd63, FC_W'($urandom_range(2, 31)), 6'd23};
		foreach (acc_sum[k])
			acc_sum[k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset filter count of 23
		queue_write(8'd255, mk_entry(5'd31, '1, '1, 1'b1, 1'b1));
		queue_write(8'd0, mk_entry(5'd0, 16'd32768, 16'd32768, 1'b1, 1'b1));
		queue_write(8'd1, mk_entry(5'd22, 16'd1000, 16'd20000, 1'b1, 1'b1));
		queue_write(8'd2, mk_entry(5'd31, '1, '1, 1'b1, 1'b1));
		queue_write(8'd3, mk_entry(5'd7, '1, '0, 1'b0, 1'b0));
		queue_write(8'd4, mk_entry(5'd3, '0, '1, 1'b0, 1'b1));
		queue_write(8'd5, mk_entry(5'd21, 16'd32768, 16'd1, 1'b1, 1'b0));
		queue_sample('1, 1'b0);
		queue_sample('0, 1'b0);
		queue_sample('1, 1'b0);
		queue_sample('1, 1'b0);
		queue_sample(32'd1, 1'b0);
		queue_sample('1, 1'b1);
		queue_sample('1, 1'b1);
		queue_sample(32'h8000_0001, 1'b0);
		queue_write(8'd1, mk_entry(5'd10, '1, 16'd32768, 1'b1, 1'b1));
		queue_sample(32'h7FFF_FFFE, 1'b0);
		queue_sample('1, 1'b1);

		foreach (fc_plan[i]) begin
			drain();
			write_filter_count(fc_plan[i]);
			gaps_on = (i != 2);
			target = queued + 24;
			while (queued < target)
				queue_frame();
		end
		drain();
		repeat (20) @(negedge clk);

		$display("covered %0d table writes and %0d samples in %0d frames, filter counts",
			writes_seen, samples_seen, frames_seen);
		$display("23 1 0 32 63 %0d; %0d energy words checked, %0d mismatches",
			fc_plan[4], energies_checked, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
